FILE: hw/rtl/rvf_pkg.sv
// shared types and constants for the vertical speed regression filter
// no dependencies; used by the arithmetic unit, the top level and the checker
package rvf_pkg;

	// datapath width of the shared multiply/divide unit
	localparam int DW = 72;
	// quotient bits produced by one division
	localparam int QW = 19;

	// configuration register indexes
	localparam logic [2:0] REG_WINDOW   = 3'd0;
	localparam logic [2:0] REG_MIN_SPAN = 3'd1;
	localparam logic [2:0] REG_LIMIT    = 3'd2;
	localparam logic [2:0] REG_FTAU     = 3'd3;
	localparam logic [2:0] REG_DEADBAND = 3'd4;
	localparam logic [2:0] REG_DTAU     = 3'd5;
	localparam logic [2:0] REG_ZTHR     = 3'd6;

	// configuration reset values
	localparam logic [15:0] RST_WINDOW   = 16'd2000;
	localparam logic [15:0] RST_MIN_SPAN = 16'd500;
	localparam logic [17:0] RST_LIMIT    = 18'd20000;
	localparam logic [15:0] RST_FTAU     = 16'd300;
	localparam logic [17:0] RST_DEADBAND = 18'd100;
	localparam logic [15:0] RST_DTAU     = 16'd1000;
	localparam logic [17:0] RST_ZTHR     = 18'd20;

	// result status codes
	localparam logic [3:0] STS_INVALID  = 4'd0;
	localparam logic [3:0] STS_DUP      = 4'd1;
	localparam logic [3:0] STS_RING_LOW = 4'd2;
	localparam logic [3:0] STS_WIN_LOW  = 4'd3;
	localparam logic [3:0] STS_SPAN     = 4'd4;
	localparam logic [3:0] STS_DEGEN    = 4'd5;
	localparam logic [3:0] STS_RANGE    = 4'd6;
	localparam logic [3:0] STS_PRIMED   = 4'd7;
	localparam logic [3:0] STS_DT_ZERO  = 4'd8;
	localparam logic [3:0] STS_FILTERED = 4'd9;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE, ST_WALK, ST_CHECK, ST_M1, ST_M2, ST_M3, ST_M4, ST_NUM,
		ST_SCALE, ST_RANGE, ST_DIV, ST_SLOPE, ST_FMUL, ST_FDIV, ST_DB,
		ST_DMUL, ST_DDIV, ST_ZT, ST_OUT
	} rvf_state_t;

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic          start;
		logic          div;
		logic [DW-1:0] opa;
		logic [DW-1:0] opb;
	} mdu_req_t;

	// response of the shared multiply/divide unit
	typedef struct packed {
		logic          busy;
		logic          done;
		logic [DW-1:0] res;
	} mdu_rsp_t;

endpackage

FILE: hw/rtl/regression_vario_filter_unit.sv
// vertical speed estimator: least-squares slope over a sample ring, then smoothing
// dropped or early samples go straight to the output; a full fit walks the ring, then
// uses the shared multiply/divide unit for four fit products and up to three 19-bit
// divisions and two filter products
// one item at a time; a new item is taken while the previous result waits at the output
// reset (arst_n low) clears ring count, head, sequence, filter state and restores registers
module regression_vario_filter_unit #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	// input samples
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // altitude[25:0], sequence_req[57:26], sample_time_ms[89:58]
	input  logic        s_tuser,  // altitude_valid
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // vertical_speed[18:0], raw_vertical_speed[37:19]
	output logic [3:0]  m_tuser   // status
);
	import rvf_pkg::*;

	localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int NW   = $clog2(HISTORY_DEPTH + 1);
	localparam int SAW  = 16 + NW;
	localparam int SA2W = 32 + NW;
	localparam int SYW  = 26 + NW;
	localparam int SAYW = 43 + NW;

	rvf_state_t state_q, state_d;
	mdu_req_t   mreq;
	mdu_rsp_t   mrsp;

	// configuration registers
	logic [15:0] window_q, min_span_q, ftau_q, dtau_q;
	logic [17:0] limit_q, deadband_q, zthr_q;

	// sample ring and control state
	logic [57:0]     ring_mem [HISTORY_DEPTH];
	logic [57:0]     rd_data_q;
	logic [AW-1:0]   head_q;
	logic [NW-1:0]   count_q;
	logic            have_q;
	logic [31:0]     last_seq_q;
	logic            primed_q;
	logic [31:0]     last_ft_q;
	logic [18:0]     sm_q;
	logic [18:0]     raw_q;
	logic [31:0]     t_q;
	logic [3:0]      status_q;

	// ring walk pipeline
	logic [NW-1:0]      rd_idx_q;
	logic               vld_s1, vld_s2, vld_s3;
	logic [15:0]        age_s2, age_s3;
	logic signed [25:0] alt_s2, alt_s3;
	logic signed [42:0] ay_s3;
	logic [31:0]        aa_s3;
	logic [31:0]        age32;
	logic               in_win;
	logic               rd_en;
	logic               walk_done;

	// fit sums
	logic [NW-1:0]          n_q;
	logic [SAW-1:0]         sa_q;
	logic [SA2W-1:0]        sa2_q;
	logic signed [SYW-1:0]  sy_q;
	logic signed [SAYW-1:0] say_q;
	logic [15:0]            span_q;

	// products and fit results
	logic [DW-1:0] p1_q, p2_q, p3_q, p4_q;
	logic [DW:0]   num_q;
	logic [DW-1:0] den_q, scl_q;
	logic          numpos_q;
	logic [18:0]   val_q;
	logic [31:0]   dt_q;
	logic          dneg_q, sneg_q;
	logic [19:0]   dmag_q;

	// combinational helpers
	logic           accept;
	logic           in_valid, in_dup;
	logic [NW-1:0]  count_nx;
	logic [SAYW-1:0] say_mag;
	logic [SYW-1:0]  sy_mag;
	logic [DW:0]    t1, t2;
	logic [DW-1:0]  num_mag;
	logic [18:0]    raw_new;
	logic [31:0]    dt_new;
	logic [19:0]    diff;
	logic [19:0]    sm_ext, sm_mag;
	logic [18:0]    quo;
	logic [19:0]    sm_add;
	logic [32:0]    fden;
	logic           out_load;

	assign accept   = s_tvalid && s_tready;
	assign in_valid = s_tuser;
	assign in_dup   = have_q && (s_tdata[57:26] == last_seq_q);
	assign count_nx = (count_q == NW'(HISTORY_DEPTH)) ? count_q : count_q + NW'(1);

	assign rd_en     = (state_q == ST_WALK) && (rd_idx_q < count_q);
	assign walk_done = !rd_en && !vld_s1 && !vld_s2 && !vld_s3;
	assign age32     = t_q - rd_data_q[57:26];
	assign in_win    = age32 <= {16'd0, window_q};

	assign say_mag = say_q[SAYW-1] ? SAYW'(-say_q) : say_q;
	assign sy_mag  = sy_q[SYW-1] ? SYW'(-sy_q) : sy_q;
	assign t1      = say_q[SAYW-1] ? (DW+1)'(-{1'b0, p1_q}) : {1'b0, p1_q};
	assign t2      = sy_q[SYW-1] ? (DW+1)'(-{1'b0, p2_q}) : {1'b0, p2_q};
	assign num_mag = num_q[DW] ? DW'(-num_q) : num_q[DW-1:0];

	assign raw_new = numpos_q ? 19'(-val_q) : val_q;
	assign dt_new  = t_q - last_ft_q;
	assign diff    = {raw_new[18], raw_new} - {sm_q[18], sm_q};
	assign sm_ext  = {sm_q[18], sm_q};
	assign sm_mag  = sm_q[18] ? 20'(-sm_ext) : sm_ext;
	assign quo     = mrsp.res[18:0];
	assign sm_add  = dneg_q ? sm_ext - {1'b0, quo} : sm_ext + {1'b0, quo};
	assign fden    = {17'd0, ftau_q} + {1'b0, dt_q};
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= RST_WINDOW;
			min_span_q <= RST_MIN_SPAN;
			limit_q    <= RST_LIMIT;
			ftau_q     <= RST_FTAU;
			deadband_q <= RST_DEADBAND;
			dtau_q     <= RST_DTAU;
			zthr_q     <= RST_ZTHR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW:   window_q   <= cfg_data[15:0];
				REG_MIN_SPAN: min_span_q <= cfg_data[15:0];
				REG_LIMIT:    limit_q    <= cfg_data;
				REG_FTAU:     ftau_q     <= cfg_data[15:0];
				REG_DEADBAND: deadband_q <= cfg_data;
				REG_DTAU:     dtau_q     <= cfg_data[15:0];
				REG_ZTHR:     zthr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample ring memory
	always_ff @(posedge clk) begin
		if (accept && in_valid && !in_dup) begin
			ring_mem[head_q] <= {s_tdata[89:58], s_tdata[25:0]};
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_idx_q[AW-1:0]];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_valid || in_dup || count_nx < NW'(3)) state_d = ST_OUT;
					else state_d = ST_WALK;
				end
			end
			ST_WALK:  if (walk_done) state_d = ST_CHECK;
			ST_CHECK: begin
				if (n_q < NW'(3) || span_q < min_span_q) state_d = ST_OUT;
				else state_d = ST_M1;
			end
			ST_M1:    if (mrsp.done) state_d = ST_M2;
			ST_M2:    if (mrsp.done) state_d = ST_M3;
			ST_M3:    if (mrsp.done) state_d = ST_M4;
			ST_M4:    if (mrsp.done) state_d = ST_NUM;
			ST_NUM:   state_d = ST_SCALE;
			ST_SCALE: state_d = (den_q == '0) ? ST_OUT : ST_RANGE;
			ST_RANGE: state_d = (scl_q >= (den_q << 19)) ? ST_OUT : ST_DIV;
			ST_DIV:   if (mrsp.done) state_d = ST_SLOPE;
			ST_SLOPE: begin
				if ({1'b0, limit_q} < val_q || !primed_q || dt_new == 32'd0) state_d = ST_OUT;
				else state_d = ST_FMUL;
			end
			ST_FMUL:  if (mrsp.done) state_d = ST_FDIV;
			ST_FDIV:  if (mrsp.done) state_d = ST_DB;
			ST_DB: begin
				if (sm_mag < {2'b0, deadband_q} && dtau_q != 16'd0 && dt_q < {16'd0, dtau_q})
					state_d = ST_DMUL;
				else
					state_d = ST_OUT;
			end
			ST_DMUL:  if (mrsp.done) state_d = ST_DDIV;
			ST_DDIV:  if (mrsp.done) state_d = ST_ZT;
			ST_ZT:    state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs: input handshake and unit requests
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mreq     = '0;
		unique case (state_q)
			ST_M1: begin
				mreq.opa = {{(DW-SAYW){1'b0}}, say_mag};
				mreq.opb = {{(DW-NW){1'b0}}, n_q};
			end
			ST_M2: begin
				mreq.opa = {{(DW-SYW){1'b0}}, sy_mag};
				mreq.opb = {{(DW-SAW){1'b0}}, sa_q};
			end
			ST_M3: begin
				mreq.opa = {{(DW-SA2W){1'b0}}, sa2_q};
				mreq.opb = {{(DW-NW){1'b0}}, n_q};
			end
			ST_M4: begin
				mreq.opa = {{(DW-SAW){1'b0}}, sa_q};
				mreq.opb = {{(DW-SAW){1'b0}}, sa_q};
			end
			ST_DIV: begin
				mreq.div = 1'b1;
				mreq.opa = scl_q;
				mreq.opb = den_q << 18;
			end
			ST_FMUL: begin
				mreq.opa = {{(DW-20){1'b0}}, dmag_q};
				mreq.opb = {{(DW-32){1'b0}}, dt_q};
			end
			ST_FDIV: begin
				mreq.div = 1'b1;
				mreq.opa = p1_q;
				mreq.opb = {{(DW-33){1'b0}}, fden} << 18;
			end
			ST_DMUL: begin
				mreq.opa = {{(DW-20){1'b0}}, sm_mag};
				mreq.opb = {{(DW-16){1'b0}}, dtau_q - dt_q[15:0]};
			end
			ST_DDIV: begin
				mreq.div = 1'b1;
				mreq.opa = p1_q;
				mreq.opb = {{(DW-16){1'b0}}, dtau_q} << 18;
			end
			default: ;
		endcase
		mreq.start = !mrsp.busy && (state_q == ST_M1 || state_q == ST_M2 ||
			state_q == ST_M3 || state_q == ST_M4 || state_q == ST_DIV ||
			state_q == ST_FMUL || state_q == ST_FDIV || state_q == ST_DMUL ||
			state_q == ST_DDIV);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// control state: ring pointers, sequence, filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			have_q     <= 1'b0;
			last_seq_q <= '0;
			primed_q   <= 1'b0;
			last_ft_q  <= '0;
			sm_q       <= '0;
			raw_q      <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1 && in_win;
			vld_s3 <= vld_s2;
			if (accept && in_valid && !in_dup) begin
				have_q     <= 1'b1;
				last_seq_q <= s_tdata[57:26];
				head_q     <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q    <= count_nx;
			end
			unique case (state_q)
				ST_SLOPE: begin
					if (!({1'b0, limit_q} < val_q)) begin
						raw_q     <= raw_new;
						last_ft_q <= t_q;
						if (!primed_q) begin
							primed_q <= 1'b1;
							sm_q     <= raw_new;
						end
					end
				end
				ST_FDIV: if (mrsp.done) sm_q <= sm_add[18:0];
				ST_DB: begin
					if (sm_mag < {2'b0, deadband_q} &&
						(dtau_q == 16'd0 || dt_q >= {16'd0, dtau_q})) begin
						sm_q <= '0;
					end
				end
				ST_DDIV: if (mrsp.done) sm_q <= sneg_q ? 19'(-quo) : quo;
				ST_ZT: if (sm_mag < {2'b0, zthr_q}) sm_q <= '0;
				default: ;
			endcase
			// output register
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// payload: walk pipeline, sums, products, status
	always_ff @(posedge clk) begin
		age_s2 <= age32[15:0];
		alt_s2 <= rd_data_q[25:0];
		age_s3 <= age_s2;
		alt_s3 <= alt_s2;
		ay_s3  <= $signed({1'b0, age_s2}) * alt_s2;
		aa_s3  <= age_s2 * age_s2;
		if (out_load) begin
			m_tdata <= {2'b00, raw_q, sm_q};
			m_tuser <= status_q;
		end
		if (accept) begin
			t_q      <= s_tdata[89:58];
			rd_idx_q <= '0;
			n_q      <= '0;
			sa_q     <= '0;
			sa2_q    <= '0;
			sy_q     <= '0;
			say_q    <= '0;
			span_q   <= '0;
			if (!in_valid) status_q <= STS_INVALID;
			else if (in_dup) status_q <= STS_DUP;
			else status_q <= STS_RING_LOW;
		end
		if (rd_en) rd_idx_q <= rd_idx_q + NW'(1);
		// accumulate windowed entries
		if (vld_s3) begin
			n_q   <= n_q + NW'(1);
			sa_q  <= sa_q + {{NW{1'b0}}, age_s3};
			sa2_q <= sa2_q + {{NW{1'b0}}, aa_s3};
			sy_q  <= sy_q + {{NW{alt_s3[25]}}, alt_s3};
			say_q <= say_q + {{NW{ay_s3[42]}}, ay_s3};
			if (age_s3 > span_q) span_q <= age_s3;
		end
		case (state_q)
			ST_CHECK: status_q <= (n_q < NW'(3)) ? STS_WIN_LOW : STS_SPAN;
			ST_M1:    if (mrsp.done) p1_q <= mrsp.res;
			ST_M2:    if (mrsp.done) p2_q <= mrsp.res;
			ST_M3:    if (mrsp.done) p3_q <= mrsp.res;
			ST_M4:    if (mrsp.done) p4_q <= mrsp.res;
			ST_NUM: begin
				num_q <= t1 - t2;
				den_q <= p3_q - p4_q;
			end
			ST_SCALE: begin
				status_q <= (den_q == '0) ? STS_DEGEN : STS_RANGE;
				numpos_q <= !num_q[DW] && (num_q != '0);
				scl_q    <= (num_mag << 10) - (num_mag << 5) + (num_mag << 3);
			end
			ST_DIV: if (mrsp.done) val_q <= mrsp.res[18:0];
			ST_SLOPE: begin
				dt_q   <= dt_new;
				dneg_q <= diff[19];
				dmag_q <= diff[19] ? 20'(-diff) : diff;
				if ({1'b0, limit_q} < val_q) status_q <= STS_RANGE;
				else if (!primed_q) status_q <= STS_PRIMED;
				else if (dt_new == 32'd0) status_q <= STS_DT_ZERO;
				else status_q <= STS_FILTERED;
			end
			ST_FMUL: if (mrsp.done) p1_q <= mrsp.res;
			ST_DB:   sneg_q <= sm_q[18];
			ST_DMUL: if (mrsp.done) p1_q <= mrsp.res;
			default: ;
		endcase
	end

	// shared multiply/divide unit
	rvf_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule

FILE: hw/rtl/rvf_mdu.sv
// shared shift-add multiplier and restoring divider, one add or subtract per cycle
// depends on rvf_pkg
module rvf_mdu (
	input  logic              clk,
	input  logic              arst_n,
	input  rvf_pkg::mdu_req_t req,
	output rvf_pkg::mdu_rsp_t rsp
);
	import rvf_pkg::*;

	logic          busy_q;
	logic          div_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] acc_q;
	logic [QW-1:0] quo_q;
	logic [4:0]    cnt_q;
	logic          done;
	logic          load;
	logic          ge;

	assign load = req.start && !busy_q;
	assign done = busy_q && (div_q ? (cnt_q == 5'd0) : (b_q == '0));
	assign ge   = acc_q >= a_q;

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= req.div;
			if (req.div) begin
				acc_q <= req.opa;
				a_q   <= req.opb;
				cnt_q <= 5'(QW);
				quo_q <= '0;
			end else begin
				acc_q <= '0;
				a_q   <= req.opa;
				b_q   <= req.opb;
			end
		end else if (busy_q && !done) begin
			if (div_q) begin
				if (ge) begin
					acc_q <= acc_q - a_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
				a_q   <= a_q >> 1;
				cnt_q <= cnt_q - 5'd1;
			end else begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done;
	assign rsp.res  = div_q ? {{(DW-QW){1'b0}}, quo_q} : acc_q;

endmodule

FILE: hw/rtl/rvf_checker.sv
// port-level checks for the vertical speed regression filter
// depends on rvf_pkg; bound to regression_vario_filter_unit below
module rvf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [3:0]  m_tuser
);
	import rvf_pkg::*;

	// a result waiting for the consumer holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one sample at a time: ready drops after each transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// status codes stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= STS_FILTERED)
		else $error("bad status code");

	// first accepted slope is adopted as the smoothed speed
	a_primed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STS_PRIMED |-> m_tdata[18:0] == m_tdata[37:19])
		else $error("priming did not adopt raw slope");

endmodule

bind regression_vario_filter_unit rvf_checker u_rvf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/regression_vario_filter_checker.sv
// checker for the vertical speed regression filter: follows configuration writes,
// predicts one speed result per accepted sample and compares the result stream
// depends on rvf_pkg for register indexes, reset values and status codes
module regression_vario_filter_checker
	import rvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [3:0]  m_tuser,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 32;

	typedef struct {
		logic signed [18:0] speed;
		logic signed [18:0] raw;
		logic [3:0]         status;
	} speed_result_t;

	speed_result_t expected_speeds[$];

	// configuration copy
	logic [15:0] window_ms, min_span_ms, ftau_ms, dtau_ms;
	logic [17:0] limit_mms, deadband_mms, zthr_mms;

	// sample ring and filter state
	logic signed [25:0] ring_alt[DEPTH];
	logic [31:0]        ring_t[DEPTH];
	int                 ring_cnt, ring_wr;
	logic               seen_sample, primed;
	logic [31:0]        prev_seq, prev_filter_t;
	longint             smooth_mms, raw_mms;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic push_speed(input logic [3:0] sts);
		speed_result_t r;
		r.speed = smooth_mms[18:0];
		r.raw = raw_mms[18:0];
		r.status = sts;
		expected_speeds.push_back(r);
	endtask

	// one accepted sample: ring update, least-squares fit, smoothing and deadband
	task automatic fit_sample(input logic signed [25:0] alt, input logic ok,
			input logic [31:0] seq, input logic [31:0] t);
		logic [31:0] ai, aj, span, dt;
		int          n;
		longint      num, den, da, dy, mg, q, val, dtl;
		if (!ok) begin
			push_speed(STS_INVALID);
			return;
		end
		if (seen_sample && seq == prev_seq) begin
			push_speed(STS_DUP);
			return;
		end
		prev_seq = seq;
		seen_sample = 1'b1;
		ring_alt[ring_wr] = alt;
		ring_t[ring_wr] = t;
		ring_wr = (ring_wr + 1) % DEPTH;
		if (ring_cnt < DEPTH) ring_cnt++;
		if (ring_cnt < 3) begin
			push_speed(STS_RING_LOW);
			return;
		end
		// sums over every windowed pair
		n = 0; span = 0; num = 0; den = 0;
		for (int i = 0; i < ring_cnt; i++) begin
			ai = t - ring_t[i];
			if (ai > {16'd0, window_ms}) continue;
			n++;
			if (ai > span) span = ai;
			for (int j = i + 1; j < ring_cnt; j++) begin
				aj = t - ring_t[j];
				if (aj > {16'd0, window_ms}) continue;
				da = longint'({32'd0, ai}) - longint'({32'd0, aj});
				dy = longint'(ring_alt[i]) - longint'(ring_alt[j]);
				num += da * dy;
				den += da * da;
			end
		end
		if (n < 3) begin
			push_speed(STS_WIN_LOW);
			return;
		end
		if (span < {16'd0, min_span_ms}) begin
			push_speed(STS_SPAN);
			return;
		end
		if (den == 0) begin
			push_speed(STS_DEGEN);
			return;
		end
		// slope magnitude in mm/s, truncated
		mg = (num < 0) ? -num : num;
		q = mg / den;
		if (q > 64'h40000) begin
			push_speed(STS_RANGE);
			return;
		end
		val = q * 1000 + ((mg % den) * 1000) / den;
		if (val > longint'({46'd0, limit_mms})) begin
			push_speed(STS_RANGE);
			return;
		end
		// ages run backward in time, so the sign flips
		raw_mms = (num > 0) ? -val : val;
		dt = primed ? t - prev_filter_t : 32'd0;
		prev_filter_t = t;
		if (!primed) begin
			primed = 1'b1;
			smooth_mms = raw_mms;
			push_speed(STS_PRIMED);
			return;
		end
		if (dt == 0) begin
			push_speed(STS_DT_ZERO);
			return;
		end
		dtl = longint'({32'd0, dt});
		smooth_mms += ((raw_mms - smooth_mms) * dtl) / (longint'({48'd0, ftau_ms}) + dtl);
		// decay toward zero inside the deadband
		if (((smooth_mms < 0) ? -smooth_mms : smooth_mms) < longint'({46'd0, deadband_mms})) begin
			if (dtau_ms == 0 || dt >= {16'd0, dtau_ms})
				smooth_mms = 0;
			else
				smooth_mms = (smooth_mms * (longint'({48'd0, dtau_ms}) - dtl)) /
					longint'({48'd0, dtau_ms});
			if (((smooth_mms < 0) ? -smooth_mms : smooth_mms) < longint'({46'd0, zthr_mms}))
				smooth_mms = 0;
		end
		push_speed(STS_FILTERED);
	endtask

	// watch configuration, sample and result transactions
	always @(posedge clk or negedge arst_n) begin
		speed_result_t e;
		if (!arst_n) begin
			window_ms = RST_WINDOW;
			min_span_ms = RST_MIN_SPAN;
			limit_mms = RST_LIMIT;
			ftau_ms = RST_FTAU;
			deadband_mms = RST_DEADBAND;
			dtau_ms = RST_DTAU;
			zthr_mms = RST_ZTHR;
			ring_cnt = 0;
			ring_wr = 0;
			seen_sample = 1'b0;
			prev_seq = '0;
			primed = 1'b0;
			prev_filter_t = '0;
			smooth_mms = 0;
			raw_mms = 0;
			expected_speeds.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW: window_ms = cfg_data[15:0];
					REG_MIN_SPAN: min_span_ms = cfg_data[15:0];
					REG_LIMIT: limit_mms = cfg_data;
					REG_FTAU: ftau_ms = cfg_data[15:0];
					REG_DEADBAND: deadband_mms = cfg_data;
					REG_DTAU: dtau_ms = cfg_data[15:0];
					REG_ZTHR: zthr_mms = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				fit_sample(s_tdata[25:0], s_tuser, s_tdata[57:26], s_tdata[89:58]);
			// compare the result transaction with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (expected_speeds.size() == 0) begin
					report_mismatch("pending results", 0, 1);
				end else begin
					e = expected_speeds.pop_front();
					if (m_tdata[18:0] !== e.speed)
						report_mismatch("vertical_speed", $signed(m_tdata[18:0]), e.speed);
					if (m_tdata[37:19] !== e.raw)
						report_mismatch("raw_vertical_speed", $signed(m_tdata[37:19]), e.raw);
					if (m_tuser !== e.status)
						report_mismatch("status", m_tuser, e.status);
				end
			end
		end
		outstanding = expected_speeds.size();
	end

endmodule

FILE: tb/regression_vario_filter_unit_test.sv
// top of the vertical speed regression filter testbench: clock, reset, configuration
// phases, sample stimulus with bursts and gaps, result stalls and the verdict
// depends on rvf_pkg, regression_vario_filter_unit and regression_vario_filter_checker
module regression_vario_filter_unit_test;
	import rvf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;
	int          errors, outstanding;
	int          cycles = 0;

	// track of a simulated climb
	logic [31:0] cur_seq, cur_time;
	longint      cur_alt, climb;
	int          burst_left = 0;

	regression_vario_filter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	regression_vario_filter_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stalls in random modes, each held for a random span
	always @(negedge clk) begin : rx_stall
		int mode_left, mode;
		if (mode_left <= 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 600);
		end
		mode_left--;
		case (mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= ($urandom_range(0, 40) == 0);
		endcase
	end

	// one sample transaction, with gaps between random bursts
	task automatic send_sample(input logic [25:0] alt, input logic vld,
			input logic [31:0] seq, input logic [31:0] t);
		if (burst_left <= 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 25)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tdata = {6'd0, t, seq, alt};
		s_tuser = vld;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// write all registers once the block has drained
	task automatic configure(input logic [17:0] win, input logic [17:0] span,
			input logic [17:0] lim, input logic [17:0] ftau, input logic [17:0] db,
			input logic [17:0] dtau, input logic [17:0] zthr);
		logic [17:0] vals[7];
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		vals = '{win, span, lim, ftau, db, dtau, zthr};
		for (int k = 0; k < 7; k++) begin
			cfg_index = k[2:0];
			cfg_data = vals[k];
			cfg_we = 1'b1;
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	// next sample of the track, or noise, a duplicate, a jump or a fresh track
	task automatic random_sample();
		int          k;
		logic [31:0] step_ms;
		k = $urandom_range(0, 99);
		if (k < 5) begin
			send_sample(26'($urandom), 1'b0, $urandom, $urandom);
		end else if (k < 10) begin
			send_sample(cur_alt[25:0], 1'b1, cur_seq, cur_time + $urandom_range(0, 500));
		end else if (k < 13) begin
			cur_seq = $urandom;
			cur_time = $urandom;
			cur_alt = longint'($urandom_range(0, 32000000)) - 2000000;
			send_sample(cur_alt[25:0], 1'b1, cur_seq, cur_time);
		end else begin
			if (k < 17) step_ms = 0;
			else if (k < 20) step_ms = $urandom_range(3000, 70000);
			else step_ms = $urandom_range(5, 150);
			if ($urandom_range(0, 25) == 0) begin
				if ($urandom_range(0, 1) == 0)
					climb = longint'($urandom_range(0, 60000)) - 30000;
				else
					climb = longint'($urandom_range(0, 400)) - 200;
			end
			cur_seq++;
			cur_time += step_ms;
			cur_alt += climb * longint'(step_ms) / 1000 + longint'($urandom_range(0, 40)) - 20;
			if (cur_alt > 30000000 || cur_alt < -2000000) begin
				cur_alt = (cur_alt > 0) ? 30000000 : -2000000;
				climb = -climb;
			end
			send_sample(cur_alt[25:0], 1'b1, cur_seq, cur_time);
		end
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) random_sample();
	endtask

	initial begin
		climb = 1500;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: invalid, first sample, duplicate, short ring, degenerate fit, filter cases
		configure(18'd2000, 18'd0, 18'd20000, 18'd300, 18'd100, 18'd1000, 18'd20);
		send_sample(26'h3ff_ffff, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
		send_sample(-26'sd2000000, 1'b1, 32'd0, 32'd1000);
		send_sample(26'd5, 1'b1, 32'd0, 32'd1200);
		send_sample(26'd30000000, 1'b1, 32'd1, 32'd1000);
		send_sample(26'd0, 1'b1, 32'd2, 32'd1000);
		send_sample(26'd1000, 1'b1, 32'd3, 32'd1100);
		send_sample(26'd1100, 1'b1, 32'd4, 32'd1200);
		send_sample(26'd1150, 1'b1, 32'd5, 32'd1200);
		send_sample(26'd1200, 1'b1, 32'd6, 32'd1300);
		send_sample(26'd1210, 1'b1, 32'd7, 32'd1400);
		send_sample(26'd1210, 1'b1, 32'd8, 32'd90000);
		send_sample(26'd1212, 1'b1, 32'd9, 32'd90100);
		send_sample(26'd2000000, 1'b1, 32'd10, 32'd90200);
		cur_seq = 32'd10;
		cur_time = 32'd90200;
		cur_alt = 1212;
		random_phase(200);

		// upper extremes of the 16-bit registers, high values of the 18-bit ones
		configure(18'd65535, 18'd65535, 18'd200000, 18'd65535, 18'd200000, 18'd65535,
			18'd200000);
		random_phase(150);

		// lower extremes, wait for every result before going on
		configure(18'd1, 18'd0, 18'd0, 18'd0, 18'd0, 18'd1, 18'd0);
		random_phase(150);

		// typical settings across the time wrap
		configure(18'd3000, 18'd500, 18'd20000, 18'd300, 18'd100, 18'd1000, 18'd20);
		cur_time = 32'hffff_f000;
		random_phase(350);

		// assorted settings
		for (int p = 0; p < 4; p++) begin
			configure(18'($urandom_range(200, 6000)), 18'($urandom_range(0, 1500)),
				18'($urandom_range(0, 200000)), 18'($urandom_range(0, 2000)),
				18'($urandom_range(0, 3000)), 18'($urandom_range(1, 3000)),
				18'($urandom_range(0, 200)));
			random_phase(150);
		end

		// drain and give the verdict
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rvf_pkg.sv
hw/rtl/rvf_mdu.sv
hw/rtl/regression_vario_filter_unit.sv
hw/rtl/rvf_checker.sv
tb/regression_vario_filter_checker.sv
tb/regression_vario_filter_unit_test.sv
